// ----- hw/rtl/binary_arithmetic_encoder_core_macros.svh -----
// assertion macros for the binary arithmetic encoder checker
`ifndef BINARY_ARITHMETIC_ENCODER_CORE_MACROS_SVH
`define BINARY_ARITHMETIC_ENCODER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BAE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bae assertion failed");

// next-cycle implication, disabled while reset is asserted
`define BAE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bae assertion failed");

`endif

// ----- hw/rtl/bae_pkg.sv -----
// shared types and constants of the binary arithmetic encoder
package bae_pkg;

  localparam int BOUND_W    = 56;  // coding interval bound width
  localparam int WORD_W     = 32;  // settled word width
  localparam int SETTLE_LSB = BOUND_W - WORD_W;
  localparam int PROB_W     = 12;
  localparam int PRE_SHIFT  = 4;
  localparam int POST_SHIFT = 8;
  localparam int PROD_W     = BOUND_W - PRE_SHIFT + PROB_W;
  localparam int WBITS_W    = 6;

  localparam logic [WBITS_W-1:0] WORD_BITS_NORMAL = WBITS_W'(WORD_W);
  localparam logic [WBITS_W-1:0] WORD_BITS_FINAL  = WBITS_W'(BOUND_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ENC_ZERO = 2'd0,
    OP_ENC_ONE  = 2'd1,
    OP_FINISH   = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [PROB_W-1:0] prob;
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } head_t;

endpackage

// ----- hw/rtl/bae_front.sv -----
// front end: accepts items, classifies them and queues them for the coder
module bae_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic                       command_i,
  input  logic                       bit_value_i,
  input  logic [bae_pkg::PROB_W-1:0] probability_i,
  input  logic                       pop_i,
  output bae_pkg::head_t             head_o
);

  bae_pkg::queue_entry_t               entry_q [bae_pkg::QUEUE_DEPTH];
  bae_pkg::queue_entry_t               new_entry;
  logic [bae_pkg::QPTR_W-1:0]          wr_ptr_q, wr_ptr_d;
  logic [bae_pkg::QPTR_W-1:0]          rd_ptr_q, rd_ptr_d;
  logic [bae_pkg::QCNT_W-1:0]          count_q, count_d;
  logic                                push;
  logic                                pop;

  always_comb begin
    new_entry.prob = probability_i;
    if (command_i) begin
      new_entry.op = bae_pkg::OP_FINISH;
    end else if (bit_value_i) begin
      new_entry.op = bae_pkg::OP_ENC_ONE;
    end else begin
      new_entry.op = bae_pkg::OP_ENC_ZERO;
    end
  end

  assign stall_o = (count_q == bae_pkg::QCNT_W'(bae_pkg::QUEUE_DEPTH));
  assign push    = valid_i && !stall_o;
  assign pop     = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == bae_pkg::QPTR_W'(bae_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == bae_pkg::QPTR_W'(bae_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_entry;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.entry = entry_q[rd_ptr_q];

endmodule

// ----- hw/rtl/bae_back.sv -----
// back end: interval update, word settling and the output register
module bae_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bae_pkg::head_t              head_i,
  output logic                        pop_o,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [bae_pkg::BOUND_W-1:0] code_word_o,
  output logic [bae_pkg::WBITS_W-1:0] word_bits_o,
  output logic                        last_o
);

  localparam int BW = bae_pkg::BOUND_W;
  localparam int SL = bae_pkg::SETTLE_LSB;
  localparam int WW = bae_pkg::WORD_W;

  logic [BW-1:0]                    low_q, low_d;
  logic [BW-1:0]                    high_q, high_d;
  logic [BW-1:0]                    width_q, width_d;  // tracks high - low
  logic [BW-1:0]                    low_n, high_n, width_n;
  logic [bae_pkg::PROD_W-1:0]       prod;
  logic [BW-1:0]                    cut;
  logic                             settled;
  logic                             emit;
  logic                             out_free;
  logic                             out_valid_q, out_valid_d;
  logic [BW-1:0]                    code_word_q, code_word_d;
  logic [bae_pkg::WBITS_W-1:0]      word_bits_q, word_bits_d;
  logic                             last_q, last_d;

  assign prod = width_q[BW-1:bae_pkg::PRE_SHIFT] * head_i.entry.prob;
  assign cut  = prod[bae_pkg::POST_SHIFT +: BW];

  assign out_free = !out_valid_q || !stall_i;
  assign pop_o    = head_i.valid && out_free;

  always_comb begin
    low_n   = low_q;
    high_n  = high_q;
    width_n = width_q;
    unique case (head_i.entry.op)
      bae_pkg::OP_ENC_ONE: begin
        high_n  = low_q + cut;
        width_n = cut;
      end
      bae_pkg::OP_ENC_ZERO: begin
        low_n   = low_q + cut + 1'b1;
        width_n = width_q - cut - 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign settled = (low_n[BW-1:SL] == high_n[BW-1:SL]);

  always_comb begin
    low_d       = low_q;
    high_d      = high_q;
    width_d     = width_q;
    emit        = 1'b0;
    code_word_d = code_word_q;
    word_bits_d = word_bits_q;
    last_d      = last_q;
    if (pop_o) begin
      if (head_i.entry.op == bae_pkg::OP_FINISH) begin
        emit        = 1'b1;
        code_word_d = {low_q[BW-1:SL], {SL{1'b1}}};
        word_bits_d = bae_pkg::WORD_BITS_FINAL;
        last_d      = 1'b1;
        low_d       = '0;
        high_d      = '1;
        width_d     = '1;
      end else if (settled) begin
        // top word settled: send it and move both bounds up one word
        emit        = 1'b1;
        code_word_d = {{(BW-WW){1'b0}}, high_n[BW-1:SL]};
        word_bits_d = bae_pkg::WORD_BITS_NORMAL;
        last_d      = 1'b0;
        low_d       = {low_n[SL-1:0], {WW{1'b0}}};
        high_d      = {high_n[SL-1:0], {WW{1'b1}}};
        width_d     = {width_n[SL-1:0], {WW{1'b1}}};
      end else begin
        low_d   = low_n;
        high_d  = high_n;
        width_d = width_n;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q       <= '0;
      high_q      <= '1;
      width_q     <= '1;
      out_valid_q <= 1'b0;
    end else begin
      low_q       <= low_d;
      high_q      <= high_d;
      width_q     <= width_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_word_q <= code_word_d;
    word_bits_q <= word_bits_d;
    last_q      <= last_d;
  end

  assign valid_o     = out_valid_q;
  assign code_word_o = code_word_q;
  assign word_bits_o = word_bits_q;
  assign last_o      = last_q;

endmodule

// ----- hw/rtl/binary_arithmetic_encoder_core.sv -----
// top level of the binary arithmetic encoder
//
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_stall_o    command_i, bit_value_i, probability_i
//  out      output     out_valid_o / out_stall_i  code_word_o, word_bits_o, last_o
//
// one item per cycle sustained while out_stall_i is low; an accepted item waits in the
// front queue, and the interval update (one 52x12 multiply and an add) is combinational
// in the back end, so a settled or finish word enters the output register as it is popped.
// reset puts the interval at its full span at once, with no clearing pass.
// while the output is stalled the two-entry queue fills, then in_stall_o is raised.
module binary_arithmetic_encoder_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        command_i,
  input  logic                        bit_value_i,
  input  logic [bae_pkg::PROB_W-1:0]  probability_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bae_pkg::BOUND_W-1:0] code_word_o,
  output logic [bae_pkg::WBITS_W-1:0] word_bits_o,
  output logic                        last_o
);

  bae_pkg::head_t head;
  logic           pop;

  bae_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_valid_i),
    .stall_o       (in_stall_o),
    .command_i     (command_i),
    .bit_value_i   (bit_value_i),
    .probability_i (probability_i),
    .pop_i         (pop),
    .head_o        (head)
  );

  bae_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .code_word_o (code_word_o),
    .word_bits_o (word_bits_o),
    .last_o      (last_o)
  );

endmodule

// ----- hw/rtl/bae_checker.sv -----
// port-level checks of the binary arithmetic encoder, bound to the top level
`include "binary_arithmetic_encoder_core_macros.svh"

module bae_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [bae_pkg::BOUND_W-1:0] code_word_o,
  input logic [bae_pkg::WBITS_W-1:0] word_bits_o,
  input logic                        last_o
);

  // a stalled result item holds
  `BAE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(code_word_o) && $stable(word_bits_o) && $stable(last_o))

  // finish words carry 56 bits with the low 24 set, normal words 32 bits
  `BAE_ASSERT_SAME(a_word_shape, clk_i, rst_ni, out_valid_o, last_o ? (word_bits_o == bae_pkg::WORD_BITS_FINAL && (&code_word_o[bae_pkg::SETTLE_LSB-1:0])) : (word_bits_o == bae_pkg::WORD_BITS_NORMAL && code_word_o[bae_pkg::BOUND_W-1:bae_pkg::WORD_W] == '0))

  // the queue only fills up behind a stalled output item
  `BAE_ASSERT_SAME(a_stall_cause, clk_i, rst_ni, $rose(in_stall_o), $past(out_valid_o && out_stall_i))

  // with the output draining, the input stall lasts a single cycle
  `BAE_ASSERT_NEXT(a_stall_release, clk_i, rst_ni, in_stall_o && !(out_valid_o && out_stall_i), !in_stall_o)

endmodule

bind binary_arithmetic_encoder_core bae_checker u_bae_checker (.*);
